### rtl/core/ihc_pkg.sv
// shared types and constants of the ipv4 receive header checker
package ihc_pkg;

    localparam int unsigned NSTAGE = 4;

    localparam logic [15:0] HDR_BYTES   = 16'd20;
    localparam logic [3:0]  VERSION_V4  = 4'h4;
    localparam logic [15:0] MF_BIT      = 16'h2000;
    localparam logic [15:0] OFFSET_MASK = 16'h1FFF;

    localparam logic [7:0] PROTO_NUM_ICMP = 8'd1;
    localparam logic [7:0] PROTO_NUM_TCP  = 8'd6;
    localparam logic [7:0] PROTO_NUM_UDP  = 8'd17;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_UNSUPPORTED = 2'd1,
        ST_CHECKSUM    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CLS_UDP  = 2'd0,
        CLS_TCP  = 2'd1,
        CLS_ICMP = 2'd2,
        CLS_NONE = 2'd3
    } t_cls;

    // per-stage load enables from the pipeline control
    typedef struct packed {
        logic [NSTAGE-1:0] en;
    } t_pipe_ctl;

endpackage

### rtl/core/ihc_pipe_ctrl.sv
// valid bits and load enables of the four-stage pipeline
module ihc_pipe_ctrl
    import ihc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_out_stall,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_pipe_ctl o_ctl
);

    logic [NSTAGE-1:0] r_vld;
    logic [NSTAGE-1:0] n_vld;
    logic [NSTAGE-1:0] rdy;

    // a stage may load when empty or when the stage after it moves on
    always_comb begin
        rdy[NSTAGE-1] = !r_vld[NSTAGE-1] || !i_out_stall;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    always_comb begin
        n_vld = r_vld;
        if (rdy[0]) begin
            n_vld[0] = i_in_valid;
        end
        for (int k = 1; k < NSTAGE; k++) begin
            if (rdy[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ctl.en    = rdy;
    assign o_in_stall  = !rdy[0];
    assign o_out_valid = r_vld[NSTAGE-1];

`ifndef SYNTHESIS
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> r_vld[0])
        else $error("accepted word did not enter first stage");

    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_vld) && i_out_stall |-> o_in_stall)
        else $error("full pipeline took a word under output stall");

    a_drain_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NSTAGE-2] && o_ctl.en[NSTAGE-1] |=> r_vld[NSTAGE-1])
        else $error("word lost between last two stages");
`endif

endmodule

### rtl/core/ihc_csum.sv
// pipelined ones'-complement header checksum over nine words
module ihc_csum
    import ihc_pkg::*;
(
    input  logic            i_clk,
    input  t_pipe_ctl       i_ctl,
    input  logic [8:0][15:0] i_words,
    output logic [15:0]     o_csum
);

    logic [2:0][17:0] r_part;
    logic [19:0]      r_total;
    logic [16:0]      r_fold1;
    logic [2:0][17:0] n_part;
    logic [15:0]      fold2;

    // three-word partial sums
    always_comb begin
        for (int g = 0; g < 3; g++) begin
            n_part[g] = 18'(i_words[3*g]) + 18'(i_words[3*g+1]) + 18'(i_words[3*g+2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r_part <= n_part;
        end
        if (i_ctl.en[1]) begin
            r_total <= 20'(r_part[0]) + 20'(r_part[1]) + 20'(r_part[2]);
        end
        if (i_ctl.en[2]) begin
            r_fold1 <= 17'(r_total[15:0]) + 17'(r_total[19:16]);
        end
    end

    // second fold cannot overflow: a carry leaves at most 6 in the low half
    assign fold2  = r_fold1[15:0] + 16'(r_fold1[16]);
    assign o_csum = ~fold2;

endmodule

### rtl/core/ipv4_rx_header_checker.sv
// top level of the ipv4 receive header checker
//
// input channel: one word per handshake carries the ten 16-bit header words in
// network order plus the buffer byte count; it is taken on a rising edge with
// i_in_valid high and o_in_stall low
// output channel: one result word per input word (status, upper-protocol class,
// payload length), handed over on an edge with o_out_valid high and i_out_stall low
// four register stages; o_out_valid rises when a taken input word has moved
// through them into the last stage
// throughput: one header per cycle while the receiver does not stall; the checksum
// adder tree is split over three stages (partial sums, total, first fold) and the
// last stage folds, compares and decides the status
// a stalled receiver holds the output word; bubbles further up still close, so
// input is taken until all four stages hold a word
// reset clears every valid bit; payload registers are left as they are
module ipv4_rx_header_checker
    import ihc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_hdr_word0,
    input  logic [15:0] i_hdr_word1,
    input  logic [15:0] i_hdr_word2,
    input  logic [15:0] i_hdr_word3,
    input  logic [15:0] i_hdr_word4,
    input  logic [15:0] i_hdr_word5,
    input  logic [15:0] i_hdr_word6,
    input  logic [15:0] i_hdr_word7,
    input  logic [15:0] i_hdr_word8,
    input  logic [15:0] i_hdr_word9,
    input  logic [15:0] i_frame_bytes,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [1:0]  o_upper_protocol,
    output logic [15:0] o_payload_length
);

    t_pipe_ctl        ctl;
    logic [8:0][15:0] sum_words;
    logic [15:0]      csum;

    // per-stage side data that rides along with the checksum
    typedef struct packed {
        logic        early_rej;  // short frame or wrong version
        logic        late_rej;   // fragment or unknown protocol
        t_cls        cls;
        logic [15:0] stored;
        logic [15:0] plen;
    } t_side;

    t_side       n_side;
    t_side [2:0] r_side;
    t_status     r_status;
    t_cls        r_cls;
    logic [15:0] r_plen;
    t_status     n_status;
    t_cls        n_cls;
    logic [3:0]  ihl;

    ihc_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_ctl       (ctl)
    );

    // stored checksum word is taken as zero in the sum, so it is left out
    assign sum_words = {i_hdr_word9, i_hdr_word8, i_hdr_word7, i_hdr_word6,
                        i_hdr_word4, i_hdr_word3, i_hdr_word2, i_hdr_word1,
                        i_hdr_word0};

    ihc_csum u_csum (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_words (sum_words),
        .o_csum  (csum)
    );

    // first stage: field decode
    assign ihl = i_hdr_word0[11:8];

    always_comb begin
        n_side.early_rej = (i_frame_bytes < HDR_BYTES) ||
                           (i_hdr_word0[15:12] != VERSION_V4);
        n_side.stored    = i_hdr_word5;
        n_side.plen      = i_hdr_word1 - {10'd0, ihl, 2'd0};
        case (i_hdr_word4[7:0])
            PROTO_NUM_UDP:  n_side.cls = CLS_UDP;
            PROTO_NUM_TCP:  n_side.cls = CLS_TCP;
            PROTO_NUM_ICMP: n_side.cls = CLS_ICMP;
            default:        n_side.cls = CLS_NONE;
        endcase
        n_side.late_rej  = ((i_hdr_word3 & OFFSET_MASK) != 16'd0) ||
                           ((i_hdr_word3 & MF_BIT) != 16'd0) ||
                           (n_side.cls == CLS_NONE);
    end

    // stages one to three carry the side data
    always_ff @(posedge i_clk) begin
        if (ctl.en[0]) begin
            r_side[0] <= n_side;
        end
        if (ctl.en[1]) begin
            r_side[1] <= r_side[0];
        end
        if (ctl.en[2]) begin
            r_side[2] <= r_side[1];
        end
    end

    // last stage: checks in order, first failure decides the status
    always_comb begin
        n_status = ST_OK;
        n_cls    = CLS_NONE;
        if (r_side[2].early_rej) begin
            n_status = ST_UNSUPPORTED;
        end else if ((r_side[2].stored != 16'd0) && (csum != r_side[2].stored)) begin
            n_status = ST_CHECKSUM;
        end else if (r_side[2].late_rej) begin
            n_status = ST_UNSUPPORTED;
        end else begin
            n_cls = r_side[2].cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.en[3]) begin
            r_status <= n_status;
            r_cls    <= n_cls;
            r_plen   <= r_side[2].plen;
        end
    end

    assign o_status         = r_status;
    assign o_upper_protocol = r_cls;
    assign o_payload_length = r_plen;

`ifndef SYNTHESIS
    a_reject_no_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> (o_upper_protocol == CLS_NONE))
        else $error("rejected header carries a protocol class");
`endif

endmodule

### tb/sv/tb_ipv4_rx_header_checker.sv
// self-checking testbench of the ipv4 receive header checker
module tb_ipv4_rx_header_checker;

    import ihc_pkg::*;

    // receiver hold-off for the back-pressure phase, and the no-progress limit
    localparam int unsigned LONG_HOLD      = 300;
    localparam int unsigned WATCHDOG_LIMIT = 4000;

    // one header word as the block sees it; word 0 sits leftmost
    typedef struct packed {
        logic [15:0]      frame_bytes;
        logic [0:9][15:0] word;
    } t_header;

    // what the block is expected to return for one header
    typedef struct packed {
        t_status     status;
        t_cls        cls;
        logic [15:0] plen;
    } t_verdict;

    // a row of the directed table; typed rows carry a hand-written verdict
    typedef struct {
        t_header  h;
        bit       typed;
        t_verdict want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n          = 1'b0;
    logic        i_in_valid       = 1'b0;
    logic        o_in_stall;
    logic [15:0] i_hdr_word0      = '0;
    logic [15:0] i_hdr_word1      = '0;
    logic [15:0] i_hdr_word2      = '0;
    logic [15:0] i_hdr_word3      = '0;
    logic [15:0] i_hdr_word4      = '0;
    logic [15:0] i_hdr_word5      = '0;
    logic [15:0] i_hdr_word6      = '0;
    logic [15:0] i_hdr_word7      = '0;
    logic [15:0] i_hdr_word8      = '0;
    logic [15:0] i_hdr_word9      = '0;
    logic [15:0] i_frame_bytes    = '0;
    logic        o_out_valid;
    logic        i_out_stall      = 1'b0;
    logic [1:0]  o_status;
    logic [1:0]  o_upper_protocol;
    logic [15:0] o_payload_length;

    // travels alongside the offered word so the monitor knows a typed verdict
    bit       offer_typed = 1'b0;
    t_verdict offer_want  = '0;

    t_verdict pending_verdicts[$];
    t_row     directed_rows[$];
    int       fail_count    = 0;
    bit       rst_done      = 1'b0;
    bit       tx_idle_on    = 1'b1;
    bit       rx_idle_on    = 1'b1;
    bit       long_hold_req = 1'b0;

    ipv4_rx_header_checker i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_hdr_word0      (i_hdr_word0),
        .i_hdr_word1      (i_hdr_word1),
        .i_hdr_word2      (i_hdr_word2),
        .i_hdr_word3      (i_hdr_word3),
        .i_hdr_word4      (i_hdr_word4),
        .i_hdr_word5      (i_hdr_word5),
        .i_hdr_word6      (i_hdr_word6),
        .i_hdr_word7      (i_hdr_word7),
        .i_hdr_word8      (i_hdr_word8),
        .i_hdr_word9      (i_hdr_word9),
        .i_frame_bytes    (i_frame_bytes),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_upper_protocol (o_upper_protocol),
        .o_payload_length (o_payload_length)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ones'-complement sum of the ten words with the checksum slot as zero,
    // end-around carry folded after every add, inverted at the end
    function automatic logic [15:0] fold_header_sum(t_header h);
        logic [16:0] acc;
        int          k;
        acc = '0;
        for (k = 0; k < 10; k++) begin
            if (k != 5) begin
                acc = acc + {1'b0, h.word[k]};
                if (acc[16]) begin
                    acc = {1'b0, acc[15:0]} + 17'd1;
                end
            end
        end
        return ~acc[15:0];
    endfunction

    // checks in priority order: frame length, version, checksum,
    // fragmentation, protocol; the first failing one decides the status
    function automatic t_verdict judge_header(t_header h);
        t_verdict    v;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        ihl    = h.word[0][11:8];
        proto  = h.word[4][7:0];
        // payload length is always computed, rejected or not, and wraps
        v.plen   = h.word[1] - {10'd0, ihl, 2'b00};
        v.status = ST_OK;
        v.cls    = CLS_NONE;
        if (h.frame_bytes < HDR_BYTES) begin
            v.status = ST_UNSUPPORTED;
        end else if (h.word[0][15:12] != VERSION_V4) begin
            v.status = ST_UNSUPPORTED;
        end else if (h.word[5] != 16'd0 && fold_header_sum(h) != h.word[5]) begin
            v.status = ST_CHECKSUM;
        end else if ((h.word[3] & OFFSET_MASK) != 16'd0 || (h.word[3] & MF_BIT) != 16'd0) begin
            v.status = ST_UNSUPPORTED;
        end else if (proto == PROTO_NUM_UDP) begin
            v.cls = CLS_UDP;
        end else if (proto == PROTO_NUM_TCP) begin
            v.cls = CLS_TCP;
        end else if (proto == PROTO_NUM_ICMP) begin
            v.cls = CLS_ICMP;
        end else begin
            v.status = ST_UNSUPPORTED;
        end
        return v;
    endfunction

    function automatic void put_row(t_header h, bit typed, t_status st, t_cls c,
                                    logic [15:0] plen);
        t_row r;
        r.h           = h;
        r.typed       = typed;
        r.want.status = st;
        r.want.cls    = c;
        r.want.plen   = plen;
        directed_rows.push_back(r);
    endfunction

    // mostly well-formed headers with random content, some with one defect
    // planted, and a share of pure noise so every input bit toggles
    function automatic t_header random_header();
        t_header     h;
        int unsigned pick;
        int unsigned k;
        pick = $urandom_range(0, 99);
        for (k = 0; k < 10; k++) begin
            h.word[k] = 16'($urandom);
        end
        h.frame_bytes = 16'($urandom);
        if (pick < 15) begin
            return h;
        end
        h.word[0][15:12] = VERSION_V4;
        h.word[0][11:8]  = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd5;
        if ($urandom_range(0, 3) != 0) begin
            h.word[1] = 16'($urandom_range(20, 1500));
        end
        // reserved and df bits random, mf clear, offset zero
        h.word[3] = {1'($urandom), 1'($urandom), 14'd0};
        case ($urandom_range(0, 2))
            0: h.word[4][7:0] = PROTO_NUM_UDP;
            1: h.word[4][7:0] = PROTO_NUM_TCP;
            default: h.word[4][7:0] = PROTO_NUM_ICMP;
        endcase
        h.frame_bytes = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(20, 16'hFFFF))
                                                    : 16'($urandom_range(20, 1600));
        h.word[5] = ($urandom_range(0, 4) == 0) ? 16'd0 : fold_header_sum(h);
        if (pick < 40) begin
            case ($urandom_range(0, 6))
                0: h.word[5] ^= 16'(1 << $urandom_range(0, 15));
                1: begin
                    k = $urandom_range(0, 9);
                    h.word[k] ^= 16'(1 << $urandom_range(0, 15));
                end
                2: h.word[3][13] = 1'b1;
                3: h.word[3][12:0] = 13'($urandom_range(1, 13'h1FFF));
                4: h.word[4][7:0] = 8'($urandom);
                5: h.frame_bytes = 16'($urandom_range(0, 19));
                default: h.word[0][15:12] = 4'($urandom);
            endcase
        end
        return h;
    endfunction

    // offer one header word and hold it until the block takes it; an idle
    // burst may come first while idling on the send side is enabled
    task automatic offer_header(input t_header h, input bit typed, input t_verdict want);
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        {i_hdr_word0, i_hdr_word1, i_hdr_word2, i_hdr_word3, i_hdr_word4,
         i_hdr_word5, i_hdr_word6, i_hdr_word7, i_hdr_word8, i_hdr_word9} <= h.word;
        i_frame_bytes <= h.frame_bytes;
        offer_typed   <= typed;
        offer_want    <= want;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
    endtask

    // monitor: on every taken input word queue its verdict, on every taken
    // result word compare against the oldest one still waiting
    always @(posedge i_clk) begin
        t_header  seen;
        t_verdict want;
        if (i_rst_n) begin
            if (i_in_valid === 1'b1 && o_in_stall === 1'b0) begin
                seen.word = {i_hdr_word0, i_hdr_word1, i_hdr_word2, i_hdr_word3,
                             i_hdr_word4, i_hdr_word5, i_hdr_word6, i_hdr_word7,
                             i_hdr_word8, i_hdr_word9};
                seen.frame_bytes = i_frame_bytes;
                pending_verdicts.push_back(offer_typed ? offer_want : judge_header(seen));
            end
            if (o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                if (pending_verdicts.size() == 0) begin
                    $error("result word with nothing expected: status %0d", o_status);
                    fail_count++;
                end else begin
                    want = pending_verdicts.pop_front();
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        fail_count++;
                    end
                    if (o_upper_protocol !== want.cls) begin
                        $error("upper_protocol: expected %0d, got %0d",
                               want.cls, o_upper_protocol);
                        fail_count++;
                    end
                    if (o_payload_length !== want.plen) begin
                        $error("payload_length: expected 0x%04h, got 0x%04h",
                               want.plen, o_payload_length);
                        fail_count++;
                    end
                end
            end
        end
    end

    // receive side: random stall bursts, runs without stalls, and one long
    // hold-off on request so the pipeline fills and stalls its input
    initial begin : result_stall_gen
        wait (rst_done);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // no-progress watchdog: counts cycles with no word taken on either side
    initial begin : watchdog
        int unsigned stuck;
        stuck = 0;
        wait (rst_done);
        while (stuck < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid === 1'b1 && o_in_stall === 1'b0) ||
                (o_out_valid === 1'b1 && i_out_stall === 1'b0)) begin
                stuck = 0;
            end else begin
                stuck++;
            end
        end
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        t_header base;
        t_header h;
        int      n;

        // reference header: v4, ihl 5, total 60, df set, udp, checksum left zero
        base.word = {16'h4500, 16'd60, 16'h1c46, 16'h4000, 16'h4011,
                     16'h0000, 16'hc0a8, 16'h0001, 16'hc0a8, 16'h00c7};
        base.frame_bytes = 16'd60;

        // directed table: extremes of every field, every protocol class, every
        // rejection reason and the priority between them
        put_row('0, 1'b1, ST_UNSUPPORTED, CLS_NONE, 16'h0000);
        put_row('1, 1'b1, ST_UNSUPPORTED, CLS_NONE, 16'hFFC3);
        h = base; h.word[5] = fold_header_sum(h);
        put_row(h, 1'b1, ST_OK, CLS_UDP, 16'd40);
        // longest frame that is still rejected, and the shortest accepted
        h.frame_bytes = 16'd19;
        put_row(h, 1'b1, ST_UNSUPPORTED, CLS_NONE, 16'd40);
        h.frame_bytes = 16'd20;
        put_row(h, 1'b1, ST_OK, CLS_UDP, 16'd40);
        h = base; h.frame_bytes = 16'hFFFF;
        put_row(h, 1'b1, ST_OK, CLS_UDP, 16'd40);
        // zero stored checksum skips the sum check for every class
        h = base; h.word[4] = 16'h4006;
        put_row(h, 1'b1, ST_OK, CLS_TCP, 16'd40);
        h = base; h.word[4] = 16'h4001;
        put_row(h, 1'b1, ST_OK, CLS_ICMP, 16'd40);
        h = base; h.word[4] = 16'hFF11; h.word[5] = fold_header_sum(h);
        put_row(h, 1'b1, ST_OK, CLS_UDP, 16'd40);
        // all-ones checksum can only match an all-zero header
        h = base; h.word[5] = 16'hFFFF;
        put_row(h, 1'b1, ST_CHECKSUM, CLS_NONE, 16'd40);
        h = base; h.word[5] = fold_header_sum(h); h.word[7] ^= 16'h0001;
        put_row(h, 1'b0, ST_OK, CLS_NONE, 16'd0);
        // fragments: mf alone, largest and smallest offset, all flag bits
        h = base; h.word[3] = MF_BIT;
        put_row(h, 1'b1, ST_UNSUPPORTED, CLS_NONE, 16'd40);
        h = base; h.word[3] = OFFSET_MASK;
        put_row(h, 1'b1, ST_UNSUPPORTED, CLS_NONE, 16'd40);
        h = base; h.word[3] = 16'h0001;
        put_row(h, 1'b1, ST_UNSUPPORTED, CLS_NONE, 16'd40);
        h = base; h.word[3] = 16'hFFFF;
        put_row(h, 1'b1, ST_UNSUPPORTED, CLS_NONE, 16'd40);
        h = base; h.word[3] = 16'h0000;
        put_row(h, 1'b1, ST_OK, CLS_UDP, 16'd40);
        // unknown protocol at both ends of the byte
        h = base; h.word[4] = 16'h4000;
        put_row(h, 1'b1, ST_UNSUPPORTED, CLS_NONE, 16'd40);
        h = base; h.word[4] = 16'h40FF;
        put_row(h, 1'b1, ST_UNSUPPORTED, CLS_NONE, 16'd40);
        h = base; h.word[0] = 16'h6500;
        put_row(h, 1'b1, ST_UNSUPPORTED, CLS_NONE, 16'd40);
        // payload length wraps below zero, tops out, and ihl zero is not checked
        h = base; h.word[0] = 16'h4F00; h.word[1] = 16'h0000;
        put_row(h, 1'b1, ST_OK, CLS_UDP, 16'hFFC4);
        h = base; h.word[1] = 16'hFFFF;
        put_row(h, 1'b1, ST_OK, CLS_UDP, 16'hFFEB);
        h = base; h.word[0] = 16'h4000; h.word[1] = 16'd100;
        put_row(h, 1'b1, ST_OK, CLS_UDP, 16'd100);
        // many end-around carries in the sum
        h = base; h.word[2] = 16'hFFFF;
        h.word[6] = 16'hFFFF; h.word[7] = 16'hFFFF; h.word[8] = 16'hFFFF; h.word[9] = 16'hFFFF;
        h.word[5] = fold_header_sum(h);
        put_row(h, 1'b0, ST_OK, CLS_NONE, 16'd0);
        // priority: short frame beats a bad sum, a bad sum beats a fragment
        h = base; h.frame_bytes = 16'd19; h.word[5] = 16'hFFFF;
        put_row(h, 1'b1, ST_UNSUPPORTED, CLS_NONE, 16'd40);
        h = base; h.word[5] = 16'hFFFF; h.word[3] = MF_BIT;
        put_row(h, 1'b1, ST_CHECKSUM, CLS_NONE, 16'd40);

        // synchronous reset held from the start, released once
        repeat (10) @(posedge i_clk);
        i_rst_n  <= 1'b1;
        rst_done = 1'b1;

        foreach (directed_rows[r]) begin
            offer_header(directed_rows[r].h, directed_rows[r].typed, directed_rows[r].want);
        end

        for (n = 0; n < 400; n++) begin
            offer_header(random_header(), 1'b0, '0);
        end

        // back-pressure: keep offering while the receiver holds off
        tx_idle_on    = 1'b0;
        long_hold_req = 1'b1;
        for (n = 0; n < 40; n++) begin
            offer_header(random_header(), 1'b0, '0);
        end
        tx_idle_on = 1'b1;

        for (n = 0; n < 300; n++) begin
            offer_header(random_header(), 1'b0, '0);
        end

        // closing stretch at full rate on both sides
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        for (n = 0; n < 100; n++) begin
            offer_header(random_header(), 1'b0, '0);
        end
        i_in_valid <= 1'b0;

        // drain, then wait on to catch any stray result word
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (2 * NSTAGE) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
